@@ rtl/e5t_pkg.sv @@
`timescale 1ns / 1ps

package e5t_pkg;

	// Frame lengths and offsets are kept in a narrow field: every threshold and
	// capture offset lies well below its maximum, so a saturated copy compares the same.
	localparam int LEN_BITS = 7;
	localparam int HL_BITS  = 6;
	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	localparam logic [LEN_BITS-1:0] ETH_LEN       = LEN_BITS'(14);
	localparam logic [LEN_BITS-1:0] ETH_VLAN_LEN  = LEN_BITS'(18);
	localparam logic [LEN_BITS-1:0] IP_MIN_LEN    = LEN_BITS'(20);
	localparam logic [LEN_BITS-1:0] TCP_LEN       = LEN_BITS'(20);
	localparam logic [LEN_BITS-1:0] UDP_LEN       = LEN_BITS'(8);
	localparam logic [HL_BITS-1:0]  HL_MIN        = HL_BITS'(20);

	// Byte positions within the Ethernet header
	localparam logic [LEN_BITS-1:0] POS_TYPE_HI   = LEN_BITS'(12);
	localparam logic [LEN_BITS-1:0] POS_TYPE_LO   = LEN_BITS'(13);
	localparam logic [LEN_BITS-1:0] POS_ITYPE_HI  = LEN_BITS'(16);
	localparam logic [LEN_BITS-1:0] POS_ITYPE_LO  = LEN_BITS'(17);

	// Offsets within the IPv4 header
	localparam logic [LEN_BITS-1:0] OFS_IHL       = LEN_BITS'(0);
	localparam logic [LEN_BITS-1:0] OFS_PROTO     = LEN_BITS'(9);
	localparam logic [LEN_BITS-1:0] OFS_SRC_FIRST = LEN_BITS'(12);
	localparam logic [LEN_BITS-1:0] OFS_SRC_LAST  = LEN_BITS'(15);
	localparam logic [LEN_BITS-1:0] OFS_DST_FIRST = LEN_BITS'(16);
	localparam logic [LEN_BITS-1:0] OFS_DST_LAST  = LEN_BITS'(19);

	// Offsets within the L4 header
	localparam logic [LEN_BITS-1:0] OFS_SPORT_LAST = LEN_BITS'(1);
	localparam logic [LEN_BITS-1:0] OFS_DPORT_LAST = LEN_BITS'(3);

	localparam logic [15:0] TYPE_VLAN = 16'h8100;
	localparam logic [15:0] TYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [7:0]  PROTO_UDP = 8'd17;
	localparam logic [7:0]  IHL_MASK  = 8'h0f;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic        is_ipv4;
		logic        is_tcp;
		logic        is_udp;
		logic        flow_valid;
		logic [7:0]  protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_l4_port;
		logic [15:0] dst_l4_port;
	} result_t;

	// Everything the verdict needs from one finished frame
	typedef struct packed {
		logic [LEN_BITS-1:0] len;
		logic                has_vlan;
		logic                is_ipv4;
		logic [HL_BITS-1:0]  hl;
		logic [7:0]          proto;
		logic [31:0]         src_ip;
		logic [31:0]         dst_ip;
		logic [15:0]         sport;
		logic [15:0]         dport;
	} frame_rec_t;

endpackage

@@ rtl/e5t_front.sv @@
`timescale 1ns / 1ps

module e5t_front #(
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                stall,
	input  e5t_pkg::in_item_t   item,
	output logic                rec_push,
	output e5t_pkg::frame_rec_t rec
);
	import e5t_pkg::*;

	logic [COUNT_BITS-1:0] cnt_q, cnt_nx;
	logic [LEN_BITS-1:0]   pos, len_nx, base, r, l4_ofs;
	logic [15:0]           type_q, type_nx;
	logic                  vlan_q, vlan_nx;
	logic [HL_BITS-1:0]    hl_q, hl_nx;
	logic [7:0]            proto_q, proto_nx, ihl_byte;
	logic [31:0]           src_q, src_nx, dst_q, dst_nx;
	logic [15:0]           sport_q, sport_nx, dport_q, dport_nx;
	logic                  take, in_ip;

	always_comb begin
		take   = push & ~stall;
		cnt_nx = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
		pos    = (|(cnt_q >> LEN_BITS)) ? LEN_MAX : cnt_q[LEN_BITS-1:0];
		len_nx = (|(cnt_nx >> LEN_BITS)) ? LEN_MAX : cnt_nx[LEN_BITS-1:0];

		type_nx  = type_q;
		vlan_nx  = vlan_q;
		hl_nx    = hl_q;
		proto_nx = proto_q;
		src_nx   = src_q;
		dst_nx   = dst_q;
		sport_nx = sport_q;
		dport_nx = dport_q;
		ihl_byte = item.data_byte & IHL_MASK;

		if (pos == POS_TYPE_HI) begin
			type_nx[15:8] = item.data_byte;
		end
		if (pos == POS_TYPE_LO) begin
			type_nx[7:0] = item.data_byte;
			if (type_nx == TYPE_VLAN) begin
				vlan_nx = 1'b1;
			end
		end
		if (vlan_nx && pos == POS_ITYPE_HI) begin
			type_nx[15:8] = item.data_byte;
		end
		if (vlan_nx && pos == POS_ITYPE_LO) begin
			type_nx[7:0] = item.data_byte;
		end

		base  = vlan_nx ? ETH_VLAN_LEN : ETH_LEN;
		in_ip = (pos >= base) && (type_nx == TYPE_IPV4);
		r     = pos - base;

		if (in_ip) begin
			if (r == OFS_IHL) begin
				hl_nx = {ihl_byte[3:0], 2'b00};
			end
			if (r == OFS_PROTO) begin
				proto_nx = item.data_byte;
			end
			if (r >= OFS_SRC_FIRST && r <= OFS_SRC_LAST) begin
				src_nx = {src_q[23:0], item.data_byte};
			end
			if (r >= OFS_DST_FIRST && r <= OFS_DST_LAST) begin
				dst_nx = {dst_q[23:0], item.data_byte};
			end
		end
		l4_ofs = r - LEN_BITS'(hl_nx);
		if (in_ip && hl_nx >= HL_MIN && r >= LEN_BITS'(hl_nx)) begin
			if (l4_ofs <= OFS_SPORT_LAST) begin
				sport_nx = {sport_q[7:0], item.data_byte};
			end else if (l4_ofs <= OFS_DPORT_LAST) begin
				dport_nx = {dport_q[7:0], item.data_byte};
			end
		end

		rec_push     = take & item.last_byte;
		rec.len      = len_nx;
		rec.has_vlan = vlan_nx;
		rec.is_ipv4  = (type_nx == TYPE_IPV4);
		rec.hl       = hl_nx;
		rec.proto    = proto_nx;
		rec.src_ip   = src_nx;
		rec.dst_ip   = dst_nx;
		rec.sport    = sport_nx;
		rec.dport    = dport_nx;
	end

	// Advance on every accepted beat; drop all frame state after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			type_q  <= '0;
			vlan_q  <= 1'b0;
			hl_q    <= '0;
			proto_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			sport_q <= '0;
			dport_q <= '0;
		end else if (take) begin
			if (item.last_byte) begin
				cnt_q   <= '0;
				type_q  <= '0;
				vlan_q  <= 1'b0;
				hl_q    <= '0;
				proto_q <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				sport_q <= '0;
				dport_q <= '0;
			end else begin
				cnt_q   <= cnt_nx;
				type_q  <= type_nx;
				vlan_q  <= vlan_nx;
				hl_q    <= hl_nx;
				proto_q <= proto_nx;
				src_q   <= src_nx;
				dst_q   <= dst_nx;
				sport_q <= sport_nx;
				dport_q <= dport_nx;
			end
		end
	end

endmodule

@@ rtl/e5t_fifo.sv @@
`timescale 1ns / 1ps

module e5t_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  e5t_pkg::frame_rec_t wr_data,
	output logic                full,
	input  logic                rd_en,
	output logic                head_valid,
	output e5t_pkg::frame_rec_t head
);
	import e5t_pkg::*;

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

	frame_rec_t            slot_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  do_wr, do_rd;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_wr      = wr_en & ~full;
	assign do_rd      = rd_en & head_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/e5t_back.sv @@
`timescale 1ns / 1ps

module e5t_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  e5t_pkg::frame_rec_t head,
	output logic                head_pop,
	output logic                empty,
	input  logic                pop,
	output e5t_pkg::result_t    result
);
	import e5t_pkg::*;

	logic                out_valid_q;
	result_t             res_q, verdict;
	logic [LEN_BITS-1:0] base, l4;
	logic                is_tcp, is_udp, short_l2, bad_ip;

	always_comb begin
		base     = head.has_vlan ? ETH_VLAN_LEN : ETH_LEN;
		l4       = base + LEN_BITS'(head.hl);
		is_tcp   = (head.proto == PROTO_TCP);
		is_udp   = (head.proto == PROTO_UDP);
		short_l2 = (head.len < ETH_LEN) || (head.len < base);
		bad_ip   = (head.len < base + IP_MIN_LEN) || (head.hl < HL_MIN) || (head.len < l4)
			|| (is_tcp && head.len < l4 + TCP_LEN) || (is_udp && head.len < l4 + UDP_LEN);

		verdict = '0;
		if (!short_l2) begin
			if (!head.is_ipv4) begin
				verdict.accepted = 1'b1;
			end else if (!bad_ip) begin
				verdict.accepted   = 1'b1;
				verdict.is_ipv4    = 1'b1;
				verdict.flow_valid = 1'b1;
				verdict.protocol   = head.proto;
				verdict.src_ip     = head.src_ip;
				verdict.dst_ip     = head.dst_ip;
				if (is_tcp || is_udp) begin
					verdict.is_tcp      = is_tcp;
					verdict.is_udp      = is_udp;
					verdict.src_l4_port = head.sport;
					verdict.dst_l4_port = head.dport;
				end
			end
		end
	end

	// Load a new verdict when the output register is free or being read
	assign head_pop = head_valid & (~out_valid_q | pop);
	assign empty    = ~out_valid_q;
	assign result   = res_q;

	always_ff @(posedge clk) begin
		if (head_pop) begin
			res_q <= verdict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (head_pop) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/ethernet_ipv4_five_tuple_parser.sv @@
`timescale 1ns / 1ps

// Ethernet / single VLAN / IPv4 / TCP-UDP five-tuple parser. Push a frame one
// byte per beat, destination MAC first, with last_byte set on its final byte;
// exactly one verdict per frame comes out of the result queue. The input side
// takes one byte every cycle while full is low: the front end is a byte counter
// (COUNT_BITS wide, saturating) plus field capture registers. On the last byte
// the captured fields move into a two-entry queue, and the back end turns the
// queue head into a verdict and holds it in a one-entry output register, so
// results also leave at one per cycle while the reader pops. After its last
// byte is accepted, a verdict passes through the queue and then the output
// register to the result ports, as soon as that register is free. full
// rises only when the reader stops popping and two further verdicts pile up
// behind the one on display; short frames (even one byte each) then run at the
// pop rate. A rejected frame (truncated, or IHL below 20 bytes) reads all zero;
// a non-IPv4 frame reads accepted with every other field zero.
module ethernet_ipv4_five_tuple_parser #(
	parameter int COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  e5t_pkg::in_item_t item,
	output logic              empty,
	input  logic              pop,
	output e5t_pkg::result_t  result
);
	import e5t_pkg::*;

	frame_rec_t rec, head;
	logic       rec_push, head_valid, head_pop;

	// Front end: count bytes and capture header fields
	e5t_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.stall    (full),
		.item     (item),
		.rec_push (rec_push),
		.rec      (rec)
	);

	// Decouple frame ends from verdict delivery
	e5t_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (rec_push),
		.wr_data    (rec),
		.full       (full),
		.rd_en      (head_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back end: length checks and the registered verdict
	e5t_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule
